>>> sv/vn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the vector normalize pipeline.
package vn_pkg;

	localparam int LANES    = 3;
	localparam int OUT_W    = 32;
	localparam int OUT_FRAC = 30;
	localparam int QUO_BITS = OUT_FRAC + 1;

	localparam logic REG_MIN_MAG = 1'b0;

	typedef struct packed {
		logic             valid;
		logic             too_small;
		logic [LANES-1:0] neg;
	} vn_ctl_t;

endpackage

>>> sv/vector3_normalize.sv
`timescale 1ns / 1ps
// Top level of the 3D vector normalize pipeline with its register port.
//
// Normalizes one vector per clock. Pulse start with x_in, y_in and z_in
// (signed fixed point, low COMP_WIDTH bits used); busy stays low, so an item
// is taken in every cycle that start is high. The result item shows on
// x_unit, y_unit, z_unit (signed Q1.30, truncated toward zero) and
// too_small for exactly one cycle with done high. Three stages form the
// absolute values, squares and their sum, COMP_WIDTH stages produce one
// square root bit each, 31 stages produce one quotient bit each for all
// three lanes in parallel, and one stage registers the result. The receiver
// cannot stall the stream, so take every result in the cycle it appears. A
// magnitude of zero or below min_magnitude (register at byte address 0,
// reset 1) gives the zero vector with too_small set. Write min_magnitude
// only while no item is in flight.
module vector3_normalize
	import vn_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_in,
	input  logic [31:0] y_in,
	input  logic [31:0] z_in,
	output logic        done,
	output logic [31:0] x_unit,
	output logic [31:0] y_unit,
	output logic [31:0] z_unit,
	output logic        too_small,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                             min_mag_sel;
	logic [31:0]                      min_magnitude_q;
	vn_ctl_t                          sq_ctl, rt_ctl;
	logic [2*COMP_WIDTH-1:0]          sq_sum;
	logic [LANES-1:0][COMP_WIDTH-1:0] sq_abs, rt_abs;
	logic [COMP_WIDTH-1:0]            rt_root;

	// The pipeline never holds, so there is nothing to back-pressure.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Register index is the word address; other indexes are ignored.
	assign min_mag_sel = (paddr[2] == REG_MIN_MAG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_magnitude_q <= 32'd1;
		end else if (psel && penable && pwrite && pready && min_mag_sel) begin
			min_magnitude_q <= pwdata;
		end
	end

	assign prdata = min_mag_sel ? min_magnitude_q : '0;

	vn_square #(.COMP_WIDTH(COMP_WIDTH)) u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start && !busy),
		.x_in     (x_in),
		.y_in     (y_in),
		.z_in     (z_in),
		.ctl_o    (sq_ctl),
		.sum_o    (sq_sum),
		.abs_o    (sq_abs)
	);

	vn_sqrt #(.COMP_WIDTH(COMP_WIDTH)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_i   (sq_ctl),
		.sum_i   (sq_sum),
		.abs_i   (sq_abs),
		.min_mag (min_magnitude_q),
		.ctl_o   (rt_ctl),
		.root_o  (rt_root),
		.abs_o   (rt_abs)
	);

	vn_div #(.COMP_WIDTH(COMP_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_i     (rt_ctl),
		.root_i    (rt_root),
		.abs_i     (rt_abs),
		.done      (done),
		.x_unit    (x_unit),
		.y_unit    (y_unit),
		.z_unit    (z_unit),
		.too_small (too_small)
	);

endmodule

>>> sv/vn_square.sv
`timescale 1ns / 1ps
// Front stages: component magnitudes, squares and their sum.
module vn_square
	import vn_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_in,
	input  logic [31:0]                        x_in,
	input  logic [31:0]                        y_in,
	input  logic [31:0]                        z_in,
	output vn_ctl_t                            ctl_o,
	output logic [2*COMP_WIDTH-1:0]            sum_o,
	output logic [LANES-1:0][COMP_WIDTH-1:0]   abs_o
);

	logic [LANES-1:0][COMP_WIDTH-1:0]   raw;
	vn_ctl_t                            ctl_s1, ctl_s2, ctl_s3;
	logic [LANES-1:0][COMP_WIDTH-1:0]   abs_s1, abs_s2, abs_s3;
	logic [LANES-1:0][2*COMP_WIDTH-1:0] sq_s2;
	logic [2*COMP_WIDTH-1:0]            sum_s3;

	assign raw[0] = x_in[COMP_WIDTH-1:0];
	assign raw[1] = y_in[COMP_WIDTH-1:0];
	assign raw[2] = z_in[COMP_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid     <= valid_in;
			ctl_s1.too_small <= 1'b0;
			for (int j = 0; j < LANES; j++) begin
				ctl_s1.neg[j] <= raw[j][COMP_WIDTH-1];
			end
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Full-scale negative maps to 2^(COMP_WIDTH-1), which fits unsigned.
	always_ff @(posedge clk) begin
		for (int j = 0; j < LANES; j++) begin
			abs_s1[j] <= raw[j][COMP_WIDTH-1] ? (~raw[j] + 1'b1) : raw[j];
			sq_s2[j]  <= abs_s1[j] * abs_s1[j];
		end
		abs_s2 <= abs_s1;
		abs_s3 <= abs_s2;
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	assign ctl_o = ctl_s3;
	assign sum_o = sum_s3;
	assign abs_o = abs_s3;

endmodule

>>> sv/vn_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit square root, one root bit per pipeline stage.
module vn_sqrt
	import vn_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vn_ctl_t                          ctl_i,
	input  logic [2*COMP_WIDTH-1:0]          sum_i,
	input  logic [LANES-1:0][COMP_WIDTH-1:0] abs_i,
	input  logic [31:0]                      min_mag,
	output vn_ctl_t                          ctl_o,
	output logic [COMP_WIDTH-1:0]            root_o,
	output logic [LANES-1:0][COMP_WIDTH-1:0] abs_o
);

	localparam int CW = COMP_WIDTH;

	vn_ctl_t                    ctl_s  [CW+1];
	logic [CW+1:0]              rem_s  [CW+1];
	logic [CW-1:0]              root_s [CW+1];
	logic [2*CW-1:0]            rad_s  [CW+1];
	logic [LANES-1:0][CW-1:0]   abs_s  [CW+1];

	assign ctl_s[0]  = ctl_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = sum_i;
	assign abs_s[0]  = abs_i;

	for (genvar k = 0; k < CW; k++) begin : g_stage
		logic [CW+1:0] rr;
		logic [CW+1:0] trial;
		logic          ge;

		// Bring down the next two radicand bits and try root bit one.
		assign rr    = {rem_s[k][CW-1:0], rad_s[k][2*CW-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = (rr >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (rr - trial) : rr;
			root_s[k+1] <= {root_s[k][CW-2:0], ge};
			rad_s[k+1]  <= rad_s[k] << 2;
			abs_s[k+1]  <= abs_s[k];
		end
	end

	// Zero magnitude is always too small, also with a zero threshold.
	always_comb begin
		ctl_o           = ctl_s[CW];
		ctl_o.too_small = (root_s[CW] == '0) || (32'(root_s[CW]) < min_mag);
	end

	assign root_o = root_s[CW];
	assign abs_o  = abs_s[CW];

endmodule

>>> sv/vn_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per stage, and result register.
module vn_div
	import vn_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vn_ctl_t                          ctl_i,
	input  logic [COMP_WIDTH-1:0]            root_i,
	input  logic [LANES-1:0][COMP_WIDTH-1:0] abs_i,
	output logic                             done,
	output logic [OUT_W-1:0]                 x_unit,
	output logic [OUT_W-1:0]                 y_unit,
	output logic [OUT_W-1:0]                 z_unit,
	output logic                             too_small
);

	localparam int CW = COMP_WIDTH;

	vn_ctl_t                        ctl_s [QUO_BITS+1];
	logic [CW-1:0]                  div_s [QUO_BITS+1];
	logic [LANES-1:0][CW:0]         rem_s [QUO_BITS+1];
	logic [LANES-1:0][QUO_BITS-1:0] quo_s [QUO_BITS+1];

	logic [LANES-1:0][OUT_W-1:0]    unit_q;
	logic                           done_q;
	logic                           small_q;

	assign ctl_s[0] = ctl_i;
	assign div_s[0] = root_i;
	assign quo_s[0] = '0;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			rem_s[0][j] = {1'b0, abs_i[j]};
		end
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		logic [LANES-1:0][CW:0]         rem_nx;
		logic [LANES-1:0][QUO_BITS-1:0] quo_nx;

		// Component never exceeds the root, so the first bit is the integer bit.
		always_comb begin
			logic [CW:0] d;
			logic [CW:0] rs;
			logic        ge;
			d = {1'b0, div_s[k]};
			for (int j = 0; j < LANES; j++) begin
				ge        = (rem_s[k][j] >= d);
				rs        = ge ? (rem_s[k][j] - d) : rem_s[k][j];
				rem_nx[j] = {rs[CW-1:0], 1'b0};
				quo_nx[j] = {quo_s[k][j][QUO_BITS-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			div_s[k+1] <= div_s[k];
			rem_s[k+1] <= rem_nx;
			quo_s[k+1] <= quo_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			small_q <= 1'b0;
		end else begin
			done_q  <= ctl_s[QUO_BITS].valid;
			small_q <= ctl_s[QUO_BITS].too_small;
		end
	end

	// Apply the sign, or drop to the zero vector.
	always_ff @(posedge clk) begin
		logic [OUT_W-1:0] mag;
		for (int j = 0; j < LANES; j++) begin
			mag = OUT_W'(quo_s[QUO_BITS][j]);
			if (ctl_s[QUO_BITS].too_small) begin
				unit_q[j] <= '0;
			end else if (ctl_s[QUO_BITS].neg[j]) begin
				unit_q[j] <= ~mag + 1'b1;
			end else begin
				unit_q[j] <= mag;
			end
		end
	end

	assign done      = done_q;
	assign too_small = small_q;
	assign x_unit    = unit_q[0];
	assign y_unit    = unit_q[1];
	assign z_unit    = unit_q[2];

endmodule

>>> sv/vn_check.sv
`timescale 1ns / 1ps
// Port-level checker for the vector normalize pipeline, with its bind.
module vn_check #(
	parameter int COMP_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] x_unit,
	input logic [31:0] y_unit,
	input logic [31:0] z_unit,
	input logic        too_small
);

	localparam int LAT = COMP_WIDTH + 35;

	// Every result traces back to an item taken a fixed latency earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching item");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && too_small) |-> (x_unit == 32'd0 && y_unit == 32'd0 && z_unit == 32'd0))
		else $error("too_small result is not the zero vector");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(x_unit) <= 32'sd1073741824 && $signed(x_unit) >= -32'sd1073741824
			&& $signed(y_unit) <= 32'sd1073741824 && $signed(y_unit) >= -32'sd1073741824
			&& $signed(z_unit) <= 32'sd1073741824 && $signed(z_unit) >= -32'sd1073741824))
		else $error("unit component out of range");

	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind vector3_normalize vn_check #(.COMP_WIDTH(COMP_WIDTH)) u_vn_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.x_unit    (x_unit),
	.y_unit    (y_unit),
	.z_unit    (z_unit),
	.too_small (too_small)
);
